>>> sv/reb_pkg.sv
`timescale 1ns / 1ps

package reb_pkg;

  // Configuration register indexes.
  localparam logic [7:0] REG_DEBOUNCE     = 8'd0;
  localparam logic [7:0] REG_DCLICK_WIN   = 8'd1;
  localparam logic [7:0] REG_HOLD_TIME    = 8'd2;
  localparam logic [7:0] REG_EVENT_ENABLE = 8'd3;

  // Reset values of the configuration registers.
  localparam logic [15:0] DEBOUNCE_RST     = 16'd80;
  localparam logic [15:0] DCLICK_WIN_RST   = 16'd300;
  localparam logic [15:0] HOLD_TIME_RST    = 16'd500;
  localparam logic [7:0]  EVENT_ENABLE_RST = 8'hFF;

  // Bit positions in the event enable mask.
  localparam int unsigned EN_RIGHT      = 0;
  localparam int unsigned EN_LEFT       = 1;
  localparam int unsigned EN_RIGHT_HOLD = 2;
  localparam int unsigned EN_LEFT_HOLD  = 3;
  localparam int unsigned EN_CLICK      = 4;
  localparam int unsigned EN_DCLICK     = 5;
  localparam int unsigned EN_HOLD_START = 6;
  localparam int unsigned EN_HOLD_STOP  = 7;

  // Quadrature codes with special meaning.
  localparam logic [1:0] QUAD_REST  = 2'd0;
  localparam logic [1:0] QUAD_CW    = 2'd1;
  localparam logic [1:0] QUAD_CCW   = 2'd2;
  localparam logic [1:0] QUAD_BOTH  = 2'd3;

  typedef struct packed {
    logic [31:0] now_ms;
    logic        clk_level;
    logic        dt_level;
    logic        switch_level;
  } in_item_t;

  typedef struct packed {
    logic right_turn;
    logic left_turn;
    logic right_hold_turn;
    logic left_hold_turn;
    logic single_click;
    logic double_click;
    logic hold_start;
    logic hold_stop;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  index;
    logic [15:0] data;
  } cfg_item_t;

endpackage

>>> sv/reb_stream_if.sv
`timescale 1ns / 1ps

// Valid/ready channel carrying one payload per transfer.
interface reb_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

>>> sv/rotary_encoder_button_decoder.sv
`timescale 1ns / 1ps

// Rotary encoder and push-button event decoder.
// in_if carries one poll per transfer: a millisecond timestamp and the raw
// CLK, DT and switch levels (switch low means pressed). out_if returns exactly
// one result per poll with eight event pulses: turns, hold-turns, single and
// double click, hold start and hold stop, each gated by its enable bit.
// cfg_if writes the debounce, double-click and hold windows and the event
// enable mask by register index; it is always ready and should only be used
// while no poll is in flight. Indexes past the last register are ignored.
// A poll is held in an input register, decoded against the block state by
// shallow logic and one 32-bit subtract, and its result is registered: the
// result register then offers it on out_if after the poll transfer.
// One poll is accepted every cycle. When the receiver stalls, the result
// register holds and the input register still takes one more poll; after
// that in_if.ready drops until the result is taken.
// Reset clears all decoder state and loads the default window settings.
module rotary_encoder_button_decoder (
  input logic                 clk_i,
  input logic                 rst_ni,
  reb_stream_if.sink          in_if,
  reb_stream_if.source        out_if,
  reb_stream_if.sink          cfg_if
);
  import reb_pkg::*;

  // Configuration registers.
  logic [15:0] debounce_q, dclick_win_q, hold_time_q;
  logic [7:0]  enable_q;

  // Pipeline registers.
  logic      in_valid_q;
  in_item_t  in_item_q;
  logic      out_valid_q;
  out_item_t out_item_q;
  logic      advance;

  // Decoder state.
  logic [31:0] last_time_q, last_time_d;
  logic [1:0]  prev_code_q, prev_code_d;
  logic armed_q, armed_d;
  logic down_q, down_d;
  logic turned_q, turned_d;
  logic holding_q, holding_d;
  logic second_ok_q, second_ok_d;
  logic pending_q, pending_d;
  logic second_rel_q, second_rel_d;
  logic hold_unrep_q, hold_unrep_d;
  logic hold_rep_q, hold_rep_d;

  out_item_t result;

  // Configuration writes.
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q   <= DEBOUNCE_RST;
      dclick_win_q <= DCLICK_WIN_RST;
      hold_time_q  <= HOLD_TIME_RST;
      enable_q     <= EVENT_ENABLE_RST;
    end else if (cfg_if.valid) begin
      case (cfg_if.payload.index)
        REG_DEBOUNCE:     debounce_q   <= cfg_if.payload.data;
        REG_DCLICK_WIN:   dclick_win_q <= cfg_if.payload.data;
        REG_HOLD_TIME:    hold_time_q  <= cfg_if.payload.data;
        REG_EVENT_ENABLE: enable_q     <= cfg_if.payload.data[7:0];
        default: ;
      endcase
    end
  end

  // Handshake: the held poll moves on whenever the result register is free.
  assign advance      = in_valid_q && (!out_valid_q || out_if.ready);
  assign in_if.ready  = !in_valid_q || advance;
  assign out_if.valid = out_valid_q;
  assign out_if.payload = out_item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_if.ready) begin
        in_valid_q <= in_if.valid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) begin
      in_item_q <= in_if.payload;
    end
    if (advance) begin
      out_item_q <= result;
    end
  end

  // Event decoding for the held poll.
  always_comb begin
    logic [31:0] delta;
    logic [1:0]  code;
    logic        pressed;
    logic        dir_left, dir_right;
    logic        single, dbl, hstart, hstop;

    code      = {in_item_q.dt_level, in_item_q.clk_level};
    pressed   = !in_item_q.switch_level;
    delta     = in_item_q.now_ms - last_time_q;
    dir_left  = 1'b0;
    dir_right = 1'b0;
    single    = 1'b0;
    dbl       = 1'b0;
    hstart    = 1'b0;
    hstop     = 1'b0;

    last_time_d  = last_time_q;
    prev_code_d  = prev_code_q;
    armed_d      = armed_q;
    down_d       = down_q;
    turned_d     = turned_q;
    holding_d    = holding_q;
    second_ok_d  = second_ok_q;
    pending_d    = pending_q;
    second_rel_d = second_rel_q;
    hold_unrep_d = hold_unrep_q;
    hold_rep_d   = hold_rep_q;

    // Press edge, accepted once the debounce window has passed.
    if (pressed && !down_d && delta > {16'd0, debounce_q}) begin
      down_d       = 1'b1;
      turned_d     = 1'b0;
      last_time_d  = in_item_q.now_ms;
      delta        = '0;
      hold_unrep_d = 1'b1;
      second_ok_d  = 1'b1;
    end
    // Release edge.
    if (!pressed && down_d && delta > {16'd0, debounce_q}) begin
      down_d      = 1'b0;
      last_time_d = in_item_q.now_ms;
      delta       = '0;
      holding_d   = 1'b0;
      if (second_ok_d && !pending_d) begin
        pending_d    = 1'b1;
        second_rel_d = 1'b0;
      end else begin
        second_rel_d = 1'b1;
      end
    end
    // Click decision after the double-click window.
    if (pending_d && delta > {16'd0, dclick_win_q}) begin
      if (!turned_d) begin
        dbl    = second_rel_d;
        single = !second_rel_d;
      end
      pending_d = 1'b0;
    end
    // Long press recognition.
    if (down_d && delta > {16'd0, hold_time_q} && !turned_d) begin
      if (pressed) begin
        holding_d   = 1'b1;
        second_ok_d = 1'b0;
      end else begin
        down_d      = 1'b0;
        holding_d   = 1'b0;
        last_time_d = in_item_q.now_ms;
      end
    end

    // Quadrature detent detection.
    if (code != prev_code_q) begin
      if (armed_q) begin
        if (code == QUAD_BOTH) begin
          armed_d   = 1'b0;
          dir_right = (prev_code_q == QUAD_CW);
          dir_left  = (prev_code_q == QUAD_CCW);
        end else if (code == QUAD_REST) begin
          armed_d   = 1'b0;
          dir_left  = (prev_code_q == QUAD_CW);
          dir_right = (prev_code_q == QUAD_CCW);
        end
      end
      if (code == QUAD_REST) begin
        armed_d = 1'b1;
      end
      prev_code_d = code;
      turned_d    = 1'b1;
      last_time_d = in_item_q.now_ms;
    end

    // Hold start and stop reporting.
    if (holding_d && hold_unrep_d) begin
      hold_unrep_d = 1'b0;
      if (enable_q[EN_HOLD_START]) begin
        hold_rep_d = 1'b1;
        hstart     = 1'b1;
      end
    end
    if (hold_rep_d && !pressed && enable_q[EN_HOLD_STOP]) begin
      hold_rep_d = 1'b0;
      hstop      = 1'b1;
    end

    result.right_turn      = dir_right && !pressed && enable_q[EN_RIGHT];
    result.left_turn       = dir_left && !pressed && enable_q[EN_LEFT];
    result.right_hold_turn = dir_right && pressed && enable_q[EN_RIGHT_HOLD];
    result.left_hold_turn  = dir_left && pressed && enable_q[EN_LEFT_HOLD];
    result.single_click    = single && enable_q[EN_CLICK];
    result.double_click    = dbl && enable_q[EN_DCLICK];
    result.hold_start      = hstart;
    result.hold_stop       = hstop;
  end

  // Decoder state advances with each poll that moves to the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_time_q  <= '0;
      prev_code_q  <= QUAD_REST;
      armed_q      <= 1'b0;
      down_q       <= 1'b0;
      turned_q     <= 1'b0;
      holding_q    <= 1'b0;
      second_ok_q  <= 1'b0;
      pending_q    <= 1'b0;
      second_rel_q <= 1'b0;
      hold_unrep_q <= 1'b0;
      hold_rep_q   <= 1'b0;
    end else if (advance) begin
      last_time_q  <= last_time_d;
      prev_code_q  <= prev_code_d;
      armed_q      <= armed_d;
      down_q       <= down_d;
      turned_q     <= turned_d;
      holding_q    <= holding_d;
      second_ok_q  <= second_ok_d;
      pending_q    <= pending_d;
      second_rel_q <= second_rel_d;
      hold_unrep_q <= hold_unrep_d;
      hold_rep_q   <= hold_rep_d;
    end
  end

endmodule
